// ===== rtl/yrd_pkg.sv =====
// Shared types and constants for the YUV to RGB565 converter with 3:2 decimation.
// No dependencies; used by yuv_to_rgb565_decimate.
package yrd_pkg;

    localparam int COEF_W  = 11;
    localparam int PIX_W   = 8;
    localparam int OUT_W   = 16;
    localparam int IDX_W   = 2;
    localparam int PHASE_W = 2;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [PHASE_W-1:0]       phase_t;

    // register indexes on the config port
    typedef enum logic [IDX_W-1:0] {
        REG_R_FROM_V = 2'd0,
        REG_G_FROM_U = 2'd1,
        REG_G_FROM_V = 2'd2,
        REG_B_FROM_U = 2'd3
    } reg_idx_t;

    // reset weights, Q8 at the default scale
    localparam coef_t RST_R_FROM_V = 11'sd359;
    localparam coef_t RST_G_FROM_U = -11'sd88;
    localparam coef_t RST_G_FROM_V = -11'sd183;
    localparam coef_t RST_B_FROM_U = 11'sd453;

    // decimation phases within a group of three
    localparam phase_t PHASE_FIRST = 2'd0;
    localparam phase_t PHASE_DROP  = 2'd2;

    localparam pix_t PIX_MAX = 8'hFF;
    localparam pix_t PIX_MIN = 8'h00;

endpackage

// ===== rtl/yuv_to_rgb565_decimate.sv =====
// Top level: YUV to RGB565 color conversion with 3:2 horizontal decimation.
// Depends on yrd_pkg (types, register indexes, reset weights).
//
// Usage:
//  - Slave stream s_*: one pixel per beat. s_tdata carries luma, chroma_u and
//    chroma_v; s_tuser carries frame_start, which restarts the decimation phase.
//  - Master stream m_*: one RGB565 pixel per beat. Of every three input pixels
//    the first two come out and the third is dropped; frame_start forces the
//    pixel it marks to be the first of a group.
//  - Config port: cfg_we/cfg_index/cfg_data write the four signed Q(FRAC_BITS)
//    chroma weights. Write only while the block is idle.
//  - Throughput: one beat per cycle in while m_tready does not stall the output;
//    the multiply/add/clamp path from input to output register is combinational.
//  - Path: a kept pixel accepted on the slave stream passes the input register,
//    then the output register, before it is shown on m_tvalid.
//  - Reset (rst_n low, async): phase back to zero, pipeline empty, weights to
//    their defaults (359, -88, -183, 453).
//  - Stall: with m_tready low the output register holds its beat, the input
//    register fills, and s_tready drops only when both are full. Dropped
//    pixels never occupy a stage.
module yuv_to_rgb565_decimate #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] luma, [15:8] chroma_u, [23:16] chroma_v
    input  logic        s_tuser,   // [0] frame_start
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pixel565
    // config write port
    input  logic        cfg_we,
    input  logic [yrd_pkg::IDX_W-1:0]  cfg_index,
    input  logic [yrd_pkg::COEF_W-1:0] cfg_data
);

    // accumulator: luma << FRAC_BITS plus two 8x11 products, with sign headroom
    localparam int BASE_W = yrd_pkg::PIX_W + FRAC_BITS + 1;
    localparam int PROD_W = yrd_pkg::PIX_W + yrd_pkg::COEF_W;
    localparam int ACC_W  = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 2;

    // weights
    yrd_pkg::coef_t coef_rv_reg, coef_gu_reg, coef_gv_reg, coef_bu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_rv_reg <= yrd_pkg::RST_R_FROM_V;
            coef_gu_reg <= yrd_pkg::RST_G_FROM_U;
            coef_gv_reg <= yrd_pkg::RST_G_FROM_V;
            coef_bu_reg <= yrd_pkg::RST_B_FROM_U;
        end
        else if (cfg_we)
        begin
            unique case (yrd_pkg::reg_idx_t'(cfg_index))
                yrd_pkg::REG_R_FROM_V: coef_rv_reg <= cfg_data;
                yrd_pkg::REG_G_FROM_U: coef_gu_reg <= cfg_data;
                yrd_pkg::REG_G_FROM_V: coef_gv_reg <= cfg_data;
                yrd_pkg::REG_B_FROM_U: coef_bu_reg <= cfg_data;
            endcase
        end
    end

    // handshake and pipeline control
    logic s_beat;
    logic out_free;
    logic s1_valid_reg;
    logic m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_beat   = s_tvalid && s_tready;

    // decimation phase
    yrd_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic keep;

    always_comb
    begin
        phase_cur  = s_tuser ? yrd_pkg::PHASE_FIRST : phase_reg;
        keep       = (phase_cur < yrd_pkg::PHASE_DROP);
        phase_next = keep ? phase_cur + 2'd1 : yrd_pkg::PHASE_FIRST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= yrd_pkg::PHASE_FIRST;
        else if (s_beat)
            phase_reg <= phase_next;
    end

    // input register: only kept pixels enter
    yrd_pkg::pix_t y_reg, u_reg, v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_beat && keep;
    end

    always_ff @(posedge clk)
    begin
        if (s_beat && keep)
        begin
            y_reg <= s_tdata[7:0];
            u_reg <= s_tdata[15:8];
            v_reg <= s_tdata[23:16];
        end
    end

    // conversion
    function automatic yrd_pkg::pix_t clamp8(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> FRAC_BITS;
        if (sh[ACC_W-1])
            clamp8 = yrd_pkg::PIX_MIN;
        else if (|sh[ACC_W-2:yrd_pkg::PIX_W])
            clamp8 = yrd_pkg::PIX_MAX;
        else
            clamp8 = sh[yrd_pkg::PIX_W-1:0];
    endfunction

    logic signed [yrd_pkg::PIX_W-1:0] du, dv;   // chroma minus 128
    logic signed [PROD_W-1:0] p_rv, p_gu, p_gv, p_bu;
    logic signed [ACC_W-1:0]  base, acc_r, acc_g, acc_b;
    yrd_pkg::pix_t r8, g8, b8;
    logic [15:0] pixel_next;

    always_comb
    begin
        du   = {~u_reg[7], u_reg[6:0]};
        dv   = {~v_reg[7], v_reg[6:0]};
        p_rv = dv * coef_rv_reg;
        p_gu = du * coef_gu_reg;
        p_gv = dv * coef_gv_reg;
        p_bu = du * coef_bu_reg;
        base  = signed'(ACC_W'({y_reg, {FRAC_BITS{1'b0}}}));
        acc_r = base + ACC_W'(p_rv);
        acc_g = base + ACC_W'(p_gu) + ACC_W'(p_gv);
        acc_b = base + ACC_W'(p_bu);
        r8 = clamp8(acc_r);
        g8 = clamp8(acc_g);
        b8 = clamp8(acc_b);
        pixel_next = {r8[7:3], g8[7:2], b8[7:3]};
    end

    // output register
    logic [15:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_free)
            m_tvalid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
            m_tdata_reg <= pixel_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("decimation phase out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && s_tuser) |=> (phase_reg == 2'd1))
        else $error("frame start did not restart phase");

    a_drop_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && !s_tuser && phase_reg == yrd_pkg::PHASE_DROP)
            |=> (phase_reg == yrd_pkg::PHASE_FIRST))
        else $error("phase did not wrap after dropped pixel");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("input stage lost a beat while stalled");

endmodule

// ===== verif/tb_yuv_to_rgb565_decimate.sv =====
// Testbench for yuv_to_rgb565_decimate: streams YUV pixels in, checks every RGB565 beat
// against an in-bench color-conversion and 3:2 decimation predictor.
// Depends on yrd_pkg (types, register indexes, reset weights) and the RTL top level.
`timescale 1ns / 100ps

module tb_yuv_to_rgb565_decimate;

    localparam int FRAC         = 8;     // Q format of the weights, DUT default
    localparam int CLK_HALF     = 4;     // 8 ns period
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 4;     // input reg + output reg, plus slack
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] luma, [15:8] chroma_u, [23:16] chroma_v
    logic        s_tuser;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] pixel565
    logic        cfg_we;
    logic [yrd_pkg::IDX_W-1:0]  cfg_index;
    logic [yrd_pkg::COEF_W-1:0] cfg_data;

    // bench copy of the block's state
    yrd_pkg::coef_t  weight_model [4];
    yrd_pkg::phase_t phase_model;
    logic [15:0]     expected_pixels [$];

    int  mismatch_count;
    int  send_idle_pct;     // percent chance the sender skips a cycle
    int  recv_idle_pct;     // percent chance the receiver stalls a cycle
    bit  holding;           // long receiver hold-off in progress
    event hold_off_ev;

    yuv_to_rgb565_decimate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] clamp_channel(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // floor of the Q sum is an arithmetic shift of a signed int
    function automatic logic [15:0] rgb565_from_yuv(yrd_pkg::pix_t y, yrd_pkg::pix_t u,
                                                     yrd_pkg::pix_t v);
        int base;
        int du;
        int dv;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        base = int'(y) <<< FRAC;
        du   = int'(u) - 128;
        dv   = int'(v) - 128;
        r = clamp_channel((base + dv * int'(weight_model[yrd_pkg::REG_R_FROM_V])) >>> FRAC);
        g = clamp_channel((base + du * int'(weight_model[yrd_pkg::REG_G_FROM_U])
                                + dv * int'(weight_model[yrd_pkg::REG_G_FROM_V])) >>> FRAC);
        b = clamp_channel((base + du * int'(weight_model[yrd_pkg::REG_B_FROM_U])) >>> FRAC);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Advance the decimation phase for an accepted pixel; queue a result if kept.
    // Phase three is unreachable but would drop like phase two.
    task automatic track_accepted(yrd_pkg::pix_t y, yrd_pkg::pix_t u, yrd_pkg::pix_t v,
                                  bit fs);
        yrd_pkg::phase_t ph;
        ph = fs ? yrd_pkg::PHASE_FIRST : phase_model;
        if (ph >= yrd_pkg::PHASE_DROP)
        begin
            phase_model = yrd_pkg::PHASE_FIRST;
        end
        else
        begin
            phase_model = ph + 2'd1;
            expected_pixels.push_back(rgb565_from_yuv(y, u, v));
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drives one beat at a falling edge, after random idle cycles, and returns
    // at the rising edge where it is accepted.
    task automatic send_pixel(yrd_pkg::pix_t y, yrd_pkg::pix_t u, yrd_pkg::pix_t v, bit fs);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u, y};
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        track_accepted(y, u, v, fs);
    endtask

    task automatic send_random_pixel(bit fs);
        send_pixel(yrd_pkg::pix_t'($urandom_range(255)), yrd_pkg::pix_t'($urandom_range(255)),
                   yrd_pkg::pix_t'($urandom_range(255)), fs);
    endtask

    // Stop offering, then wait for every expected result plus the pipe depth.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Only called while drained. Raises the strobe with index and data, then drops it.
    task automatic write_weight(yrd_pkg::reg_idx_t idx, yrd_pkg::coef_t w);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        weight_model[idx] = w;
    endtask

    task automatic write_all_weights(yrd_pkg::coef_t rv, yrd_pkg::coef_t gu,
                                     yrd_pkg::coef_t gv, yrd_pkg::coef_t bu);
        write_weight(yrd_pkg::REG_R_FROM_V, rv);
        write_weight(yrd_pkg::REG_G_FROM_U, gu);
        write_weight(yrd_pkg::REG_G_FROM_V, gv);
        write_weight(yrd_pkg::REG_B_FROM_U, bu);
    endtask

    function automatic yrd_pkg::coef_t random_weight();
        return yrd_pkg::coef_t'($urandom_range(2047));
    endfunction

    // ------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        $display("%0t ns: %s: expected %h got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holding)
                m_tready <= 1'b0;
            else if ($urandom_range(99) < recv_idle_pct)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    // long hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_off_ev);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    initial
    begin
        logic [15:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("unexpected pixel565 beat", 16'h0000, m_tdata);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("pixel565 mismatch", want, m_tdata);
                end
            end
        end
    end

    // Watchdog: too long with no beat on either side ends the run.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_pixels.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset weights, field extremes, and frame_start landing on each phase.
    task automatic test_reset_weights_directed();
        send_pixel(8'd0,   8'd128, 8'd128, 1'b1);  // phase 0, neutral chroma
        send_pixel(8'd255, 8'd128, 8'd128, 1'b0);  // phase 1
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // phase 2, dropped
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // clamps high
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);  // clamps low
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);  // dropped
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd17,  8'd200, 8'd40,  1'b1);  // start on a drop slot: kept
        send_pixel(8'd99,  8'd60,  8'd220, 1'b1);  // start on phase 1
        send_pixel(8'd1,   8'd1,   8'd254, 1'b1);  // back-to-back starts
        send_pixel(8'd254, 8'd254, 8'd1,   1'b0);
        send_pixel(8'd128, 8'd127, 8'd129, 1'b0);  // dropped
        send_pixel(8'd0,   8'd129, 8'd129, 1'b0);  // small negative sums floor down
        send_pixel(8'd0,   8'd127, 8'd127, 1'b0);
        send_pixel(8'd170, 8'd85,  8'd170, 1'b0);  // dropped
        send_pixel(8'd85,  8'd170, 8'd85,  1'b1);
        wait_drained();
    endtask

    // Weights at both ends of their range against extreme chroma.
    task automatic test_weight_extremes();
        yrd_pkg::coef_t settings [3][4];
        yrd_pkg::pix_t  levels   [3];
        levels = '{8'd0, 8'd128, 8'd255};
        settings[0] = '{11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023};
        settings[1] = '{-11'sd1024, -11'sd1024, -11'sd1024, -11'sd1024};
        settings[2] = '{11'sd1023, -11'sd1024, 11'sd1023, -11'sd1024};
        for (int s = 0; s < 3; s++)
        begin
            write_all_weights(settings[2'(s)][0], settings[2'(s)][1],
                              settings[2'(s)][2], settings[2'(s)][3]);
            for (int k = 0; k < 18; k++)
                send_pixel(k[0] ? 8'd255 : 8'd0, levels[2'((k / 2) % 3)],
                           levels[2'(k / 6)], k == 0);
            wait_drained();
        end
    endtask

    // A long stretch with no idling on either side.
    task automatic test_full_rate_burst();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_pixel(1'b1);
        for (int i = 1; i < 100; i++)
            send_random_pixel(i % 37 == 0);
        wait_drained();
        send_idle_pct = 12;
        recv_idle_pct = 12;
    endtask

    // Frames of random length with random content; a few stray frame starts.
    task automatic test_random_frames();
        int left;
        int flen;
        for (int s = 0; s < 6; s++)
        begin
            if (s == 0)
                write_all_weights(yrd_pkg::RST_R_FROM_V, yrd_pkg::RST_G_FROM_U,
                                  yrd_pkg::RST_G_FROM_V, yrd_pkg::RST_B_FROM_U);
            else
                write_all_weights(random_weight(), random_weight(),
                                  random_weight(), random_weight());
            left = 110;
            while (left > 0)
            begin
                // mostly short lines, sometimes 1..3 pixels to hit each restart slot
                flen = ($urandom_range(9) == 0) ? $urandom_range(3, 1)
                                                : $urandom_range(40, 4);
                for (int i = 0; i < flen && left > 0; i++)
                begin
                    send_random_pixel(i == 0 || $urandom_range(99) < 3);
                    left--;
                end
            end
            wait_drained();
        end
    endtask

    // Receiver holds off while the sender keeps offering: the pipe fills and
    // s_tready must drop without losing or duplicating a beat.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        -> hold_off_ev;
        send_random_pixel(1'b1);
        for (int i = 1; i < 80; i++)
            send_random_pixel(1'b0);
        send_idle_pct = 12;
        wait_drained();
    endtask

    // Sender pauses mid-frame until everything is out, then resumes the phase.
    task automatic test_sender_pause();
        send_random_pixel(1'b1);
        for (int i = 1; i < 20; i++)
            send_random_pixel(1'b0);
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_random_pixel(1'b0);
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        send_idle_pct  = 12;
        recv_idle_pct  = 12;
        phase_model    = yrd_pkg::PHASE_FIRST;
        weight_model[yrd_pkg::REG_R_FROM_V] = yrd_pkg::RST_R_FROM_V;
        weight_model[yrd_pkg::REG_G_FROM_U] = yrd_pkg::RST_G_FROM_U;
        weight_model[yrd_pkg::REG_G_FROM_V] = yrd_pkg::RST_G_FROM_V;
        weight_model[yrd_pkg::REG_B_FROM_U] = yrd_pkg::RST_B_FROM_U;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_weights_directed();
        test_weight_extremes();
        test_full_rate_burst();
        test_random_frames();
        test_output_backpressure();
        test_sender_pause();

        if (mismatch_count == 0 && expected_pixels.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
